### src/spmq_pkg.sv
`default_nettype none
package spmq_pkg;
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_PUSH  = 3'd1;
    localparam logic [2:0] REQ_POP   = 3'd2;
    localparam logic [2:0] REQ_PEEK  = 3'd3;
    localparam logic [2:0] REQ_COUNT = 3'd4;
    localparam logic [2:0] REQ_CLOSE = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_NO_RES = 2'd3;

    localparam int REQ_BITS = 3;
    localparam int QID_BITS = 6;
    localparam int ITEM_BITS = 32;
    localparam int LEN_BITS = 11;

    // classified request from front to back
    typedef struct packed {
        logic [2:0]           req;
        logic                 valid_id;
        logic [QID_BITS-1:0]  qid;
        logic [ITEM_BITS-1:0] item;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [QID_BITS-1:0]  given;
        logic [ITEM_BITS-1:0] data;
        logic [LEN_BITS-1:0]  len;
    } rsp_t;
endpackage
`default_nettype wire

### src/spmq_front.sv
`default_nettype none
module spmq_front #(
    parameter int QUEUES = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [47:0]         s_tdata,
    output spmq_pkg::cmd_t           cmd,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready
);
    import spmq_pkg::*;

    // two-entry queue
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push, pop;

    always_comb begin
        c.req      = s_tdata[2:0];
        c.qid      = s_tdata[8:3];
        c.item     = s_tdata[40:9];
        c.valid_id = (c.qid != '0) && ({26'd0, c.qid} < QUEUES);
    end

    assign s_tready  = cnt_reg != 2'd2;
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = cnt_reg != 2'd0;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/spmq_back.sv
`default_nettype none
module spmq_back #(
    parameter int QUEUES = 64,
    parameter int NODES = 1024,
    parameter int DATA_BITS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire spmq_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    output spmq_pkg::rsp_t      rsp,
    output logic                rsp_valid,
    input  wire logic           rsp_ready
);
    import spmq_pkg::*;

    localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CB = $clog2(NODES + 1);
    localparam int QB = $clog2(QUEUES);
    localparam int SB = $clog2(QUEUES);
    localparam int CLR_N = (NODES > QUEUES) ? NODES : QUEUES;
    localparam int CLRB = $clog2(CLR_N + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [DATA_BITS-1:0] data_mem [NODES];
    logic [NB-1:0]        link_mem [NODES];
    logic [NB-1:0]        first_mem [QUEUES];
    logic [NB-1:0]        last_mem [QUEUES];
    logic [CB-1:0]        len_mem [QUEUES];
    logic [QB-1:0]        stk_mem [QUEUES];

    logic [2:0]  state_reg;
    logic [CLRB-1:0] clr_reg;
    logic [NB-1:0] free_head_reg;
    logic [CB-1:0] free_cnt_reg;
    logic [SB-1:0] sp_reg;
    cmd_t        c_reg;
    logic [QB-1:0] q;
    logic        alloc_pass_reg;
    logic [QB-1:0] aq_reg;
    logic [NB-1:0] first_rd_reg, last_rd_reg, link_rd_reg;
    logic [CB-1:0] len_rd_reg;
    logic [QB-1:0] stk_rd_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_out_reg;
    logic        rv_reg;

    // allocate: second pass looks up the granted queue
    assign q = alloc_pass_reg ? aq_reg : QB'(c_reg.qid);
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp = rsp_out_reg;
    assign rsp_valid = rv_reg;

    function automatic logic [LEN_BITS-1:0] xl(input logic [CB-1:0] v);
        return LEN_BITS'(v);
    endfunction

    always_ff @(posedge aclk) begin
        // queue table, stack reads
        first_rd_reg <= first_mem[q];
        last_rd_reg  <= last_mem[q];
        len_rd_reg   <= len_mem[q];
        stk_rd_reg   <= stk_mem[QB'(sp_reg - 1'b1)];
        // node reads in S_RD2: link of the free head for push, else of the head node; head node data
        if (state_reg == S_RD2) begin
            link_rd_reg <= link_mem[(c_reg.req == REQ_PUSH) ? free_head_reg : first_rd_reg];
            data_rd_reg <= data_mem[first_rd_reg];
        end
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            free_head_reg <= '0;
            free_cnt_reg <= CB'(NODES);
            sp_reg <= SB'(QUEUES - 1);
            rv_reg <= 1'b0;
            alloc_pass_reg <= 1'b0;
        end else begin
            if (rv_reg && rsp_ready) rv_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    if (clr_reg < CLRB'(NODES))
                        link_mem[clr_reg[NB-1:0]] <= (clr_reg == CLRB'(NODES - 1)) ? '0
                                                     : NB'(clr_reg + 1'b1);
                    if (clr_reg < CLRB'(QUEUES)) begin
                        first_mem[clr_reg[QB-1:0]] <= '0;
                        last_mem[clr_reg[QB-1:0]]  <= '0;
                        len_mem[clr_reg[QB-1:0]]   <= '0;
                        stk_mem[clr_reg[QB-1:0]]   <= QB'(clr_reg + 1'b1);
                    end
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLRB'(CLR_N - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: if (cmd_valid) begin
                    c_reg <= cmd;
                    alloc_pass_reg <= 1'b0;
                    state_reg <= S_RD1;
                end
                S_RD1: state_reg <= S_RD2;
                S_RD2: begin
                    if (alloc_pass_reg) begin
                        state_reg <= S_OUT;
                        rsp_reg.len <= (rsp_reg.status == ST_OK) ? xl(len_rd_reg) : '0;
                    end else state_reg <= S_EXE;
                end
                S_EXE: begin
                    rsp_reg <= '{ST_OK, '0, '0, '0};
                    case (c_reg.req)
                        REQ_ALLOC: begin
                            if (sp_reg != '0) begin
                                sp_reg <= sp_reg - 1'b1;
                                rsp_reg.given <= QID_BITS'(stk_rd_reg);
                                // length of that queue is read on a second pass
                            end else rsp_reg.status <= ST_NO_RES;
                        end
                        REQ_PUSH, REQ_POP, REQ_PEEK, REQ_COUNT, REQ_CLOSE: begin
                            if (!c_reg.valid_id) rsp_reg.status <= ST_BAD_ID;
                            else case (c_reg.req)
                                REQ_PUSH: begin
                                    if (free_cnt_reg == '0) begin
                                        rsp_reg.status <= ST_NO_RES;
                                        rsp_reg.len <= xl(len_rd_reg);
                                    end else begin
                                        free_head_reg <= link_rd_reg;
                                        free_cnt_reg <= free_cnt_reg - 1'b1;
                                        data_mem[free_head_reg] <= DATA_BITS'(c_reg.item);
                                        if (len_rd_reg != '0)
                                            link_mem[last_rd_reg] <= free_head_reg;
                                        else first_mem[q] <= free_head_reg;
                                        last_mem[q] <= free_head_reg;
                                        len_mem[q] <= len_rd_reg + 1'b1;
                                        rsp_reg.len <= xl(len_rd_reg + 1'b1);
                                    end
                                end
                                REQ_POP, REQ_PEEK: begin
                                    if (len_rd_reg == '0) rsp_reg.status <= ST_EMPTY;
                                    else begin
                                        rsp_reg.data <= ITEM_BITS'(data_rd_reg);
                                        rsp_reg.len <= xl(len_rd_reg);
                                        if (c_reg.req == REQ_POP) begin
                                            rsp_reg.len <= xl(len_rd_reg - 1'b1);
                                            len_mem[q] <= len_rd_reg - 1'b1;
                                            if (len_rd_reg == CB'(1)) begin
                                                first_mem[q] <= '0;
                                                last_mem[q] <= '0;
                                            end else first_mem[q] <= link_rd_reg;
                                            link_mem[first_rd_reg] <= free_head_reg;
                                            free_head_reg <= first_rd_reg;
                                            free_cnt_reg <= free_cnt_reg + 1'b1;
                                        end
                                    end
                                end
                                REQ_COUNT: rsp_reg.len <= xl(len_rd_reg);
                                default: begin
                                    if (len_rd_reg != '0) begin
                                        link_mem[last_rd_reg] <= free_head_reg;
                                        free_head_reg <= first_rd_reg;
                                        free_cnt_reg <= free_cnt_reg + len_rd_reg;
                                    end
                                    first_mem[q] <= '0;
                                    last_mem[q] <= '0;
                                    len_mem[q] <= '0;
                                    if (sp_reg != SB'(QUEUES - 1)) begin
                                        stk_mem[sp_reg[QB-1:0]] <= q;
                                        sp_reg <= sp_reg + 1'b1;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                    state_reg <= (c_reg.req == REQ_ALLOC) ? S_RD1 : S_OUT;
                    alloc_pass_reg <= (c_reg.req == REQ_ALLOC);
                    aq_reg <= stk_rd_reg;
                end
                S_OUT: begin
                    // hand over once the output register is free
                    if (!rv_reg || rsp_ready) begin
                        rsp_out_reg <= rsp_reg;
                        rv_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/shared_pool_multi_queue_manager.sv
`default_nettype none
// path from request to result: front queue, two table read states, execute, output;
// allocate adds a second pass through the read states to read the granted queue's length
// the back part takes no new request until the last result is handed to the output, as it
// reads and then writes the node and queue memories; a result still waiting at the output holds the back part
// reset: synchronous active low; afterwards a clearing pass
// chains the free list and clears the queue tables before requests are carried out
module shared_pool_multi_queue_manager #(
    parameter int QUEUES = 64,
    parameter int NODES = 1024,
    parameter int DATA_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // req_type, queue_id, item, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // status, given_id, item_out, length, zero pad
);
    import spmq_pkg::*;

    cmd_t cmd;
    rsp_t rsp;
    logic cmd_valid, cmd_ready;

    // front: accept and classify request
    spmq_front #(.QUEUES(QUEUES)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cmd, .cmd_valid, .cmd_ready
    );

    // back: carry out request on the shared pool
    spmq_back #(.QUEUES(QUEUES), .NODES(NODES), .DATA_BITS(DATA_BITS)) u_back (
        .aclk, .aresetn, .cmd, .cmd_valid, .cmd_ready,
        .rsp, .rsp_valid(m_tvalid), .rsp_ready(m_tready)
    );

    assign m_tdata = {5'd0, rsp.len, rsp.data, rsp.given, rsp.status};
endmodule
`default_nettype wire

### sim/tb_shared_pool_multi_queue_manager.sv
`default_nettype none
module tb_shared_pool_multi_queue_manager;
    timeunit 1ns;
    timeprecision 1ps;
    import spmq_pkg::*;

    localparam int QUEUES = 64;
    localparam int NODES = 1024;
    localparam int CYCLE_LIMIT = 1500000;

    // lowest field last, as packed on m_tdata
    typedef struct packed {
        logic [10:0] length;
        logic [31:0] item_out;
        logic [5:0]  given_id;
        logic [1:0]  status;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    shared_pool_multi_queue_manager i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the pool and queue tables
    logic [31:0] pool_word [NODES];
    logic [9:0]  pool_next [NODES];
    logic [9:0]  spare_head;
    int          spare_count;
    logic [9:0]  q_head [QUEUES];
    logic [9:0]  q_tail [QUEUES];
    int          q_len [QUEUES];
    logic [5:0]  id_pool [QUEUES-1];
    int          id_top;
    reply_t      expected_replies[$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_off = 0;      // long receiver stall, in cycles
    int          rx_wait = 0;       // receiver idle cycles before the next result
    bit          fast_mode = 0;     // stretches with no idling

    // model of the manager: updates the shadow tables and returns the expected result
    function automatic reply_t queue_model(logic [2:0] req, logic [5:0] qid, logic [31:0] w);
        reply_t r;
        logic [9:0] nd;
        r = '0;
        if (req == REQ_ALLOC) begin
            if (id_top > 0) begin
                id_top--;
                r.given_id = id_pool[id_top];
                r.length = 11'(q_len[r.given_id]);
            end else begin
                r.status = ST_NO_RES;
            end
        end else if (req <= REQ_CLOSE) begin
            if (qid == 0) begin
                r.status = ST_BAD_ID;
            end else if (req == REQ_PUSH) begin
                if (spare_count == 0) begin
                    r.status = ST_NO_RES;
                end else begin
                    nd = spare_head;
                    spare_head = pool_next[nd];
                    spare_count--;
                    pool_word[nd] = w;
                    if (q_len[qid] > 0) pool_next[q_tail[qid]] = nd;
                    else q_head[qid] = nd;
                    q_tail[qid] = nd;
                    q_len[qid]++;
                end
                r.length = 11'(q_len[qid]);
            end else if (req == REQ_POP || req == REQ_PEEK) begin
                if (q_len[qid] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    nd = q_head[qid];
                    r.item_out = pool_word[nd];
                    if (req == REQ_POP) begin
                        q_len[qid]--;
                        if (q_len[qid] == 0) begin
                            q_head[qid] = 0;
                            q_tail[qid] = 0;
                        end else begin
                            q_head[qid] = pool_next[nd];
                        end
                        pool_next[nd] = spare_head;
                        spare_head = nd;
                        spare_count++;
                    end
                end
                r.length = 11'(q_len[qid]);
            end else if (req == REQ_COUNT) begin
                r.length = 11'(q_len[qid]);
            end else begin
                // close: splice the whole list back in one step
                if (q_len[qid] > 0) begin
                    pool_next[q_tail[qid]] = spare_head;
                    spare_head = q_head[qid];
                    spare_count += q_len[qid];
                end
                q_head[qid] = 0;
                q_tail[qid] = 0;
                q_len[qid] = 0;
                if (id_top < QUEUES - 1) begin
                    id_pool[id_top] = qid;
                    id_top++;
                end
            end
        end
        return r;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // one request: optional gap, then hold valid until accepted
    task automatic send_request(logic [2:0] req, logic [5:0] qid, logic [31:0] w);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        s_tdata <= {7'd0, w, qid, req};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_replies.push_back(queue_model(req, qid, w));
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        wait_cycles(12);
    endtask

    // receiver: random idle count per result, always ready in fast mode, or a long hold-off when asked
    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (fast_mode) begin
            m_tready <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            draw = $urandom_range(0, 15);
            if (draw == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_wait <= draw - 1;
            end
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[50:0];
            if (expected_replies.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.given_id !== want.given_id) begin
                    $error("given_id exp %0d got %0d", want.given_id, got.given_id);
                    errors++;
                end
                if (got.item_out !== want.item_out) begin
                    $error("item_out exp %h got %h", want.item_out, got.item_out);
                    errors++;
                end
                if (got.length !== want.length) begin
                    $error("length exp %0d got %0d", want.length, got.length);
                    errors++;
                end
                if (m_tdata[55:51] !== '0) begin
                    $error("pad exp 0 got %h", m_tdata[55:51]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ids the random part may target: 0 with a chance of one in twenty, else any of 1 to 63
    function automatic logic [5:0] pick_qid();
        if ($urandom_range(0, 19) == 0) return 6'd0;
        return 6'($urandom_range(1, 63));
    endfunction

    task automatic test_directed();
        send_request(REQ_POP, 6'd5, 32'd0);            // empty queue
        send_request(REQ_PEEK, 6'd5, 32'd0);
        send_request(REQ_PUSH, 6'd0, 32'hFFFF_FFFF);   // invalid id
        send_request(REQ_POP, 6'd0, 32'd0);
        send_request(REQ_PEEK, 6'd0, 32'd0);
        send_request(REQ_COUNT, 6'd0, 32'd0);
        send_request(REQ_CLOSE, 6'd0, 32'd0);
        send_request(REQ_ALLOC, 6'd0, 32'd0);
        send_request(REQ_PUSH, 6'd63, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 6'd63, 32'h0000_0000);
        send_request(REQ_PUSH, 6'd63, 32'hA5A5_5A5A);
        send_request(REQ_PEEK, 6'd63, 32'd0);
        send_request(REQ_COUNT, 6'd63, 32'd0);
        send_request(REQ_POP, 6'd63, 32'd0);
        send_request(REQ_ALLOC, 6'd63, 32'd0);         // id in use keeps contents
        send_request(3'd6, 6'd63, 32'h1234_5678);      // unused codes
        send_request(3'd7, 6'd1, 32'hFFFF_FFFF);
        send_request(REQ_CLOSE, 6'd63, 32'd0);          // close gives the id back to the stack
        send_request(REQ_POP, 6'd63, 32'd0);
        send_request(REQ_CLOSE, 6'd1, 32'd0);
        drain_replies();
    endtask

    // use up all ids, then one more
    task automatic test_id_exhaustion();
        repeat (QUEUES) send_request(REQ_ALLOC, 6'($urandom), 32'd0);
        for (int i = 1; i < QUEUES; i++) send_request(REQ_CLOSE, 6'(i), 32'd0);
        drain_replies();
    endtask

    // fill the pool past its end with the receiver held off at first, then pop and close all queues
    task automatic test_pool_full();
        fast_mode = 1;
        hold_off = 400;
        repeat (NODES + 3) send_request(REQ_PUSH, 6'($urandom_range(1, 63)), $urandom);
        fast_mode = 0;
        repeat (20) send_request(REQ_POP, 6'($urandom_range(1, 63)), 32'd0);
        for (int i = 1; i < QUEUES; i++) send_request(REQ_CLOSE, 6'(i), 32'd0);
        drain_replies();
    endtask

    // mostly sensible traffic with random content and some noise
    task automatic test_random(int n);
        int sel;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 20) fast_mode = ~fast_mode;
            sel = $urandom_range(0, 99);
            if (sel < 40) send_request(REQ_PUSH, pick_qid(), $urandom);
            else if (sel < 62) send_request(REQ_POP, pick_qid(), $urandom);
            else if (sel < 72) send_request(REQ_PEEK, pick_qid(), $urandom);
            else if (sel < 80) send_request(REQ_COUNT, pick_qid(), $urandom);
            else if (sel < 88) send_request(REQ_ALLOC, pick_qid(), $urandom);
            else if (sel < 96) send_request(REQ_CLOSE, pick_qid(), $urandom);
            else send_request(3'($urandom_range(6, 7)), 6'($urandom), $urandom);
        end
        fast_mode = 0;
        drain_replies();
    endtask

    initial begin
        for (int i = 0; i < NODES; i++) pool_next[i] = 10'((i + 1) % NODES);
        spare_head = 0;
        spare_count = NODES;
        for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = 0;
            q_tail[i] = 0;
            q_len[i] = 0;
        end
        for (int i = 0; i < QUEUES - 1; i++) id_pool[i] = 6'(i + 1);
        id_top = QUEUES - 1;

        wait_cycles(10);
        aresetn <= 1'b1;
        test_directed();
        test_id_exhaustion();
        test_pool_full();
        test_random(100);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
src/spmq_pkg.sv
src/spmq_front.sv
src/spmq_back.sv
src/shared_pool_multi_queue_manager.sv
sim/tb_shared_pool_multi_queue_manager.sv
